@@ rtl/command_line_argument_splitter_defines.svh @@
// Assertion macros used by the command line argument splitter checker.
`ifndef COMMAND_LINE_ARGUMENT_SPLITTER_DEFINES_SVH
`define COMMAND_LINE_ARGUMENT_SPLITTER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define CLS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define CLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/clsplit_pkg.sv @@
// Package with types and constants of the command line argument splitter.
`timescale 1ns / 1ps
package clsplit_pkg;

  localparam int unsigned RunCntW    = 6;
  localparam int unsigned CountW     = 15;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CountW-1:0] CountMax = 15'h7FFF;

  localparam logic KindChar = 1'b0;
  localparam logic KindEnd  = 1'b1;

  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChVtab      = 8'h0B;
  localparam logic [7:0] ChFormFeed  = 8'h0C;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;

  typedef struct packed {
    logic [RunCntW-1:0] nslash;
    logic               tail_valid;
    logic [7:0]         tail_byte;
    logic [CountW-1:0]  arg_count;
    logic               overflow;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } front_out_t;

endpackage

@@ rtl/clsplit_in_if.sv @@
// Input channel interface: one command line byte or end marker per transfer.
`timescale 1ns / 1ps
interface clsplit_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] ch;

  modport source (output valid, output kind, output ch, input ready);
  modport sink (input valid, input kind, input ch, output ready);
endinterface

@@ rtl/clsplit_out_if.sv @@
// Output channel interface: one emitted argument byte per transfer.
`timescale 1ns / 1ps
interface clsplit_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [14:0] arg_count;
  logic        overflow;
  logic        last;

  modport source (output valid, output out_byte, output arg_count, output overflow,
                  output last, input ready);
  modport sink (input valid, input out_byte, input arg_count, input overflow,
                input last, output ready);
endinterface

@@ rtl/clsplit_fifo.sv @@
// Short command queue between the parser front end and the byte emitter.
`timescale 1ns / 1ps
module clsplit_fifo
  import clsplit_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ rtl/clsplit_front.sv @@
// Parser front end: classifies each byte, updates the quoting state, and builds commands.
`timescale 1ns / 1ps
module clsplit_front
  import clsplit_pkg::*;
#(
  parameter int unsigned SLASH_LIMIT = 63
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  clsplit_in_if.sink    in_i,
  input  logic          full_i,
  output front_out_t    front_o
);

  localparam int unsigned RunW = $clog2(SLASH_LIMIT + 1);
  localparam logic [RunW-1:0] RunLimit = RunW'(SLASH_LIMIT);

  logic              quoted_q, quoted_d;
  logic              inside_q, inside_d;
  logic              pending_q, pending_d;
  logic [RunW-1:0]   run_q, run_d;
  logic [CountW-1:0] total_q, total_d;
  logic              ovf_q, ovf_d;
  logic [RunW-1:0]   nslash;
  logic              tail_valid;
  logic [7:0]        tail_byte;
  logic              do_plain, want_begin, want_slash, is_blank, accept;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign is_blank   = (in_i.ch == ChSpace) || (in_i.ch == ChTab) ||
                      (in_i.ch == ChVtab) || (in_i.ch == ChFormFeed);

  always_comb begin
    quoted_d   = quoted_q;
    inside_d   = inside_q;
    pending_d  = pending_q;
    run_d      = run_q;
    total_d    = total_q;
    ovf_d      = ovf_q;
    nslash     = '0;
    tail_valid = 1'b0;
    tail_byte  = in_i.ch;
    do_plain   = 1'b0;
    want_begin = 1'b0;
    want_slash = 1'b0;

    if (in_i.kind == KindEnd) begin
      pending_d  = 1'b0;
      if (pending_q) begin
        quoted_d = 1'b0;
      end
      nslash     = run_q;
      run_d      = '0;
      tail_valid = 1'b1;
      tail_byte  = ChNul;
    end else if (pending_q) begin
      pending_d = 1'b0;
      if (in_i.ch == ChQuote) begin
        tail_valid = 1'b1;
      end else begin
        quoted_d = 1'b0;
        do_plain = 1'b1;
      end
    end else if (run_q != '0) begin
      if (in_i.ch == ChBackslash) begin
        want_slash = 1'b1;
      end else if (in_i.ch == ChQuote) begin
        run_d  = '0;
        nslash = run_q >> 1;
        if (run_q[0]) begin
          tail_valid = 1'b1;
        end else begin
          do_plain = 1'b1;
        end
      end else begin
        run_d    = '0;
        nslash   = run_q;
        do_plain = 1'b1;
      end
    end else begin
      do_plain = 1'b1;
    end

    if (do_plain) begin
      if (in_i.ch == ChBackslash) begin
        want_begin = 1'b1;
        want_slash = 1'b1;
      end else if (in_i.ch == ChQuote) begin
        if (!quoted_d) begin
          quoted_d   = 1'b1;
          want_begin = 1'b1;
        end else begin
          pending_d = 1'b1;
        end
      end else if (is_blank) begin
        if (quoted_d) begin
          tail_valid = 1'b1;
        end else if (inside_d) begin
          inside_d   = 1'b0;
          tail_valid = 1'b1;
          tail_byte  = ChNul;
        end
      end else begin
        tail_valid = 1'b1;
        want_begin = 1'b1;
      end
    end

    if (want_slash) begin
      if (run_d < RunLimit) begin
        run_d = run_d + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (want_begin && !inside_d) begin
      inside_d = 1'b1;
      if (total_d != CountMax) begin
        total_d = total_d + 1'b1;
      end
    end

    front_o.cmd.nslash     = RunCntW'(nslash);
    front_o.cmd.tail_valid = tail_valid;
    front_o.cmd.tail_byte  = tail_byte;
    front_o.cmd.arg_count  = total_d;
    front_o.cmd.overflow   = ovf_d;
    front_o.push           = accept && (tail_valid || (nslash != '0));

    if (in_i.kind == KindEnd) begin
      quoted_d  = 1'b0;
      inside_d  = 1'b0;
      pending_d = 1'b0;
      run_d     = '0;
      total_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quoted_q  <= 1'b0;
      inside_q  <= 1'b0;
      pending_q <= 1'b0;
      run_q     <= '0;
      total_q   <= '0;
      ovf_q     <= 1'b0;
    end else if (accept) begin
      quoted_q  <= quoted_d;
      inside_q  <= inside_d;
      pending_q <= pending_d;
      run_q     <= run_d;
      total_q   <= total_d;
      ovf_q     <= ovf_d;
    end
  end

endmodule

@@ rtl/clsplit_back.sv @@
// Byte emitter: expands each queued command into its backslash run and final byte.
`timescale 1ns / 1ps
module clsplit_back
  import clsplit_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  cmd_t          cmd_i,
  output logic          pop_o,
  clsplit_out_if.source out_o
);

  logic               busy_q, busy_d;
  logic [RunCntW-1:0] rem_q, rem_d;
  logic               tail_v_q, tail_v_d;
  logic [7:0]         tail_q, tail_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  logic               is_last, step, finish;

  assign is_last = (rem_q == '0) || ((rem_q == RunCntW'(1)) && !tail_v_q);
  assign step    = busy_q && out_o.ready;
  assign finish  = step && is_last;
  assign pop_o   = !empty_i && (!busy_q || finish);

  assign out_o.valid     = busy_q;
  assign out_o.out_byte  = (rem_q != '0) ? ChBackslash : tail_q;
  assign out_o.arg_count = cnt_q;
  assign out_o.overflow  = ovf_q;
  assign out_o.last      = is_last;

  always_comb begin
    busy_d   = busy_q;
    rem_d    = rem_q;
    tail_v_d = tail_v_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    if (pop_o) begin
      busy_d   = 1'b1;
      rem_d    = cmd_i.nslash;
      tail_v_d = cmd_i.tail_valid;
      tail_d   = cmd_i.tail_byte;
      cnt_d    = cmd_i.arg_count;
      ovf_d    = cmd_i.overflow;
    end else if (finish) begin
      busy_d = 1'b0;
    end else if (step) begin
      rem_d = rem_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    tail_v_q <= tail_v_d;
    tail_q   <= tail_d;
    cnt_q    <= cnt_d;
    ovf_q    <= ovf_d;
  end

endmodule

@@ rtl/command_line_argument_splitter.sv @@
// Top level of the command line argument splitter.
//
//   Channel | Direction | Payload                                | Transfer
//   in_i    | sink      | kind, ch                               | valid && ready
//   out_o   | source    | out_byte, arg_count, overflow, last    | valid && ready
//
// An input byte is parsed in the cycle it is transferred; one result leaves per ready cycle.
// A backslash run of n bytes followed by a byte gives up to n + 1 results.
// The front end stalls only when the two-entry command queue is full.
// Reset clears the quoting state, the argument count and the overflow flag.
`timescale 1ns / 1ps
module command_line_argument_splitter
  import clsplit_pkg::*;
#(
  parameter int unsigned SLASH_LIMIT = 63
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  clsplit_in_if.sink    in_i,
  clsplit_out_if.source out_o
);

  front_out_t front;
  cmd_t       queued;
  logic       full, empty, pop;

  clsplit_front #(
    .SLASH_LIMIT(SLASH_LIMIT)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .front_o(front)
  );

  clsplit_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front.push),
    .data_i (front.cmd),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (queued)
  );

  clsplit_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(empty),
    .cmd_i  (queued),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

@@ rtl/clsplit_checker.sv @@
// Port-level checker of the command line argument splitter and its bind.
`timescale 1ns / 1ps
`include "command_line_argument_splitter_defines.svh"
module clsplit_checker
  import clsplit_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [7:0]        out_byte_i,
  input logic [CountW-1:0] arg_count_i,
  input logic              overflow_i,
  input logic              last_i
);

  `CLS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_byte_i) && $stable(last_i), "Output changed while stalled.")
  `CLS_ASSERT_SAME(a_run_is_backslash, out_valid_i && !last_i, out_byte_i == ChBackslash, "Non-final result is not a backslash.")
  `CLS_ASSERT_NEXT(a_item_continues, out_valid_i && out_ready_i && !last_i, out_valid_i && $stable(arg_count_i) && $stable(overflow_i), "Results of one item disagree.")
  `CLS_ASSERT_NEXT(a_overflow_sticky, out_valid_i && out_ready_i && overflow_i, !out_valid_i || overflow_i, "Overflow flag cleared.")
  `CLS_ASSERT_SAME(a_count_nonzero, out_valid_i && (out_byte_i != ChNul), arg_count_i != '0, "Argument byte with zero count.")

endmodule

bind command_line_argument_splitter clsplit_checker u_clsplit_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_byte_i (out_o.out_byte),
  .arg_count_i(out_o.arg_count),
  .overflow_i (out_o.overflow),
  .last_i     (out_o.last)
);
